// ===== src/cqkr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character queue package
// Field widths, command and error codes, controller states and the command
// and status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cqkr_pkg;

    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 5;
    localparam int FILL_W = 5;
    localparam int ERR_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_DUMP   = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_POSITION  = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_REM_RD,
        ST_REM_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_DMP_RD,
        ST_DMP_OUT,
        ST_RESP
    } t_state;

    // Offset from the head that selects the ring slot of a store access.
    typedef enum logic [2:0] {
        OFS_IDX,
        OFS_IDX_M1,
        OFS_WPTR,
        OFS_COUNT,
        OFS_HEAD
    } t_ofs;

    typedef enum logic {
        WSRC_CHAR,
        WSRC_RDATA
    } t_wsrc;

    typedef struct packed {
        logic  in_ready;
        logic  rd_en;
        logic  wr_en;
        t_ofs  ofs;
        t_wsrc wsrc;
        logic  idx_clr;
        logic  idx_from_cnt;
        logic  idx_inc;
        logic  idx_dec;
        logic  wptr_clr;
        logic  wptr_inc;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  cnt_from_wptr;
        logic  head_inc;
        logic  clear_all;
        logic  err_set;
        t_err  err;
        logic  res_load;
        logic  emit;
        logic  emit_dump;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic in_valid;
        logic full;
        logic empty;
        logic pos_bad;
        logic idx_at_cnt;
        logic idx_below_pos;
        logic last_entry;
        logic key_miss;
        logic out_free;
    } t_sts;

endpackage

// ===== src/cqkr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command word into the queue.
// ----------------------------------------------------------------------------
interface cqkr_in_if;
    import cqkr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] in_char;
    logic [POS_W-1:0]  position;

    modport source (output valid, output cmd, output in_char, output position, input ready);
    modport sink   (input valid, input cmd, input in_char, input position, output ready);
endinterface

// ===== src/cqkr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result word out of the queue.
// ----------------------------------------------------------------------------
interface cqkr_out_if;
    import cqkr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
    logic [ERR_W-1:0]  error_code;
    logic              last;

    modport source (output valid, output out_char, output fill_count, output is_empty,
                    output error_code, output last, input ready);
    modport sink   (input valid, input out_char, input fill_count, input is_empty,
                    input error_code, input last, output ready);
endinterface

// ===== src/char_queue_with_key_remove_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character queue with key removal
// Bounded FIFO of byte characters in a ring store, with push, pop,
// remove-by-key, insert-at-position, dump and clear commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake     Payload
//  i_in      in         valid/ready   cmd, in_char, position
//  o_out     out        valid/ready   out_char, fill_count, is_empty,
//                                     error_code, last
//
// One command word is taken at a time; i_in.ready is high only while the
// controller is idle. Pop reads the head entry; remove-key reads each stored
// entry and writes each survivor back towards the head; insert moves each
// entry from the position on up one slot; dump reads each entry in turn.
// All go through the entry store, with its shared address and registered read.
// Results pass through an output register, so the controller moves on while
// a word waits there; it stalls only when a new word must be loaded while
// the register is still full and o_out.ready is low.
// Reset is synchronous and active low; it empties the queue at once. The
// store itself is not cleared, since only entries that were written are read.
//
module char_queue_with_key_remove_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cqkr_in_if.sink     i_in,
    cqkr_out_if.source  o_out
);
    import cqkr_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    // The controller decides the sequence of store accesses for a command.
    cqkr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    // The datapath holds the queue state, the store and the result register.
    cqkr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

// ===== src/cqkr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cqkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== src/cqkr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character queue datapath
// Head, count and walk pointers, the ring address, the entry store and the
// result register.
// ----------------------------------------------------------------------------
module cqkr_dp #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cqkr_pkg::t_ctl  i_ctl,
    output cqkr_pkg::t_sts  o_sts,
    cqkr_in_if.sink         i_in,
    cqkr_out_if.source      o_out
);
    import cqkr_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] HEAD_MAX = IW'(DEPTH - 1);

    logic [IW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_wptr;
    t_cmd              r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [POS_W-1:0]  r_pos;
    t_err              r_err;
    logic [CHAR_W-1:0] r_res_char;

    logic              r_ov;
    logic [CHAR_W-1:0] r_oc;
    logic [FILL_W-1:0] r_ofill;
    logic              r_oempty;
    t_err              r_oerr;
    logic              r_olast;

    logic [CW-1:0]     w_ofs;
    logic [CW:0]       w_sum;
    logic [CW:0]       w_slot;
    logic [IW-1:0]     w_addr;
    logic [CHAR_W-1:0] w_wdata;
    logic [CHAR_W-1:0] w_rdata;
    logic              w_take;
    logic              w_free;
    logic [XW-1:0]     w_cnt_x;

    assign w_take = i_in.valid && i_ctl.in_ready;
    assign w_free = !r_ov || o_out.ready;
    assign i_in.ready = i_ctl.in_ready;

    // Ring slot of an offset from the head: the sum stays below twice DEPTH.
    always_comb begin
        case (i_ctl.ofs)
            OFS_IDX:    w_ofs = r_idx;
            OFS_IDX_M1: w_ofs = r_idx - CW'(1);
            OFS_WPTR:   w_ofs = r_wptr;
            OFS_COUNT:  w_ofs = r_count;
            default:    w_ofs = '0;
        endcase
    end

    assign w_sum   = (CW + 1)'(r_head) + (CW + 1)'(w_ofs);
    assign w_slot  = (w_sum >= DEPTH_S) ? (w_sum - DEPTH_S) : w_sum;
    assign w_addr  = w_slot[IW-1:0];
    assign w_wdata = (i_ctl.wsrc == WSRC_RDATA) ? w_rdata : r_char;

    cqkr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wdata),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rdata)
    );

    // Queue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_wptr  <= '0;
            r_err   <= ERR_OK;
        end else begin
            if (i_ctl.clear_all) begin
                r_head  <= '0;
                r_count <= '0;
            end else begin
                if (i_ctl.head_inc) begin
                    r_head <= (r_head == HEAD_MAX) ? '0 : r_head + IW'(1);
                end
                if (i_ctl.cnt_inc) begin
                    r_count <= r_count + CW'(1);
                end else if (i_ctl.cnt_dec) begin
                    r_count <= r_count - CW'(1);
                end else if (i_ctl.cnt_from_wptr) begin
                    r_count <= r_wptr;
                end
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_from_cnt) begin
                r_idx <= r_count;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_ctl.idx_dec) begin
                r_idx <= r_idx - CW'(1);
            end
            if (i_ctl.wptr_clr) begin
                r_wptr <= '0;
            end else if (i_ctl.wptr_inc) begin
                r_wptr <= r_wptr + CW'(1);
            end
            if (i_ctl.err_set) begin
                r_err <= i_ctl.err;
            end
        end
    end

    // Captured command word and the character of the pending result.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd      <= t_cmd'(i_in.cmd);
            r_char     <= i_in.in_char;
            r_pos      <= i_in.position;
            r_res_char <= '0;
        end else if (i_ctl.res_load) begin
            r_res_char <= w_rdata;
        end
    end

    assign w_cnt_x = XW'(r_count);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_ofill  <= w_cnt_x[FILL_W-1:0];
            r_oempty <= (r_count == '0);
            if (i_ctl.emit_dump) begin
                r_oc    <= w_rdata;
                r_oerr  <= ERR_OK;
                r_olast <= o_sts.last_entry;
            end else begin
                r_oc    <= r_res_char;
                r_oerr  <= r_err;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_char   = r_oc;
    assign o_out.fill_count = r_ofill;
    assign o_out.is_empty   = r_oempty;
    assign o_out.error_code = r_oerr;
    assign o_out.last       = r_olast;

    // Status towards the controller.
    always_comb begin
        o_sts.cmd           = r_cmd;
        o_sts.in_valid      = i_in.valid;
        o_sts.full          = (r_count == DEPTH_C);
        o_sts.empty         = (r_count == '0);
        o_sts.pos_bad       = (r_pos == '0) || (XW'(r_pos) > w_cnt_x);
        o_sts.idx_at_cnt    = (r_idx == r_count);
        o_sts.idx_below_pos = (XW'(r_idx) < XW'(r_pos));
        o_sts.last_entry    = ((r_idx + CW'(1)) == r_count);
        o_sts.key_miss      = (w_rdata != r_char);
        o_sts.out_free      = w_free;
    end
endmodule

// ===== src/cqkr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character queue controller
// Sequences each command over the datapath, one store access per cycle.
// ----------------------------------------------------------------------------
module cqkr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cqkr_pkg::t_sts  i_sts,
    output cqkr_pkg::t_ctl  o_ctl
);
    import cqkr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.err = ERR_OK;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_ctl.err_set = 1'b1;
                n_state = ST_RESP;
                unique case (i_sts.cmd)
                    CMD_PUSH: begin
                        if (i_sts.full) begin
                            o_ctl.err = ERR_OVERFLOW;
                        end else begin
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.ofs     = OFS_COUNT;
                            o_ctl.wsrc    = WSRC_CHAR;
                            o_ctl.cnt_inc = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (i_sts.empty) begin
                            o_ctl.err = ERR_UNDERFLOW;
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            o_ctl.ofs   = OFS_HEAD;
                            n_state     = ST_POP_WAIT;
                        end
                    end
                    CMD_REMOVE: begin
                        o_ctl.idx_clr  = 1'b1;
                        o_ctl.wptr_clr = 1'b1;
                        n_state        = ST_REM_RD;
                    end
                    CMD_INSERT: begin
                        if (i_sts.full) begin
                            o_ctl.err = ERR_OVERFLOW;
                        end else if (i_sts.pos_bad) begin
                            o_ctl.err = ERR_POSITION;
                        end else begin
                            o_ctl.idx_from_cnt = 1'b1;
                            n_state            = ST_INS_RD;
                        end
                    end
                    CMD_DUMP: begin
                        if (!i_sts.empty) begin
                            o_ctl.idx_clr = 1'b1;
                            n_state       = ST_DMP_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        o_ctl.clear_all = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_POP_WAIT: begin
                o_ctl.res_load = 1'b1;
                o_ctl.head_inc = 1'b1;
                o_ctl.cnt_dec  = 1'b1;
                n_state        = ST_RESP;
            end
            ST_REM_RD: begin
                if (i_sts.idx_at_cnt) begin
                    o_ctl.cnt_from_wptr = 1'b1;
                    n_state             = ST_RESP;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_ctl.ofs   = OFS_IDX;
                    n_state     = ST_REM_WR;
                end
            end
            ST_REM_WR: begin
                if (i_sts.key_miss) begin
                    o_ctl.wr_en    = 1'b1;
                    o_ctl.ofs      = OFS_WPTR;
                    o_ctl.wsrc     = WSRC_RDATA;
                    o_ctl.wptr_inc = 1'b1;
                end
                o_ctl.idx_inc = 1'b1;
                n_state       = ST_REM_RD;
            end
            ST_INS_RD: begin
                if (i_sts.idx_below_pos) begin
                    o_ctl.wr_en   = 1'b1;
                    o_ctl.ofs     = OFS_IDX;
                    o_ctl.wsrc    = WSRC_CHAR;
                    o_ctl.cnt_inc = 1'b1;
                    n_state       = ST_RESP;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_ctl.ofs   = OFS_IDX_M1;
                    n_state     = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.ofs     = OFS_IDX;
                o_ctl.wsrc    = WSRC_RDATA;
                o_ctl.idx_dec = 1'b1;
                n_state       = ST_INS_RD;
            end
            ST_DMP_RD: begin
                o_ctl.rd_en = 1'b1;
                o_ctl.ofs   = OFS_IDX;
                n_state     = ST_DMP_OUT;
            end
            ST_DMP_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.emit_dump = 1'b1;
                    o_ctl.idx_inc   = 1'b1;
                    n_state = i_sts.last_entry ? ST_IDLE : ST_DMP_RD;
                end
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== bench/cqkr_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character queue result checker
// Watches the command and result channels, works out the result words that
// each accepted command should give, and compares them in order with the
// words that the queue returns.
// ----------------------------------------------------------------------------
module cqkr_result_check #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cqkr_in_if   i_cmd,
    cqkr_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import cqkr_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [FILL_W-1:0] fill;
        logic              empty;
        t_err              err;
        logic              last;
    } t_result_word;

    // Shadow copy of the queue contents.
    logic [CHAR_W-1:0] ring [DEPTH];
    int unsigned       head_slot;
    int unsigned       occupancy;
    t_result_word      awaited_q [$];

    function automatic int unsigned slot_of(int unsigned offset);
        return (head_slot + offset) % DEPTH;
    endfunction

    function automatic t_result_word status_word(logic [CHAR_W-1:0] ch, t_err err,
                                                 logic last);
        t_result_word r;
        r.ch    = ch;
        r.fill  = FILL_W'(occupancy);
        r.empty = (occupancy == 0);
        r.err   = err;
        r.last  = last;
        return r;
    endfunction

    function automatic void predict_command(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                            logic [POS_W-1:0] pos);
        int unsigned       kept;
        int unsigned       i;
        logic [CHAR_W-1:0] v;
        case (op)
            CMD_PUSH: begin
                if (occupancy >= DEPTH) begin
                    awaited_q.push_back(status_word('0, ERR_OVERFLOW, 1'b1));
                end else begin
                    ring[slot_of(occupancy)] = ch;
                    occupancy++;
                    awaited_q.push_back(status_word('0, ERR_OK, 1'b1));
                end
            end
            CMD_POP: begin
                if (occupancy == 0) begin
                    awaited_q.push_back(status_word('0, ERR_UNDERFLOW, 1'b1));
                end else begin
                    v         = ring[slot_of(0)];
                    head_slot = slot_of(1);
                    occupancy--;
                    awaited_q.push_back(status_word(v, ERR_OK, 1'b1));
                end
            end
            CMD_REMOVE: begin
                // Compact the survivors towards the head, keeping their order.
                kept = 0;
                for (i = 0; i < occupancy; i++) begin
                    v = ring[slot_of(i)];
                    if (v != ch) begin
                        ring[slot_of(kept)] = v;
                        kept++;
                    end
                end
                occupancy = kept;
                awaited_q.push_back(status_word('0, ERR_OK, 1'b1));
            end
            CMD_INSERT: begin
                if (occupancy >= DEPTH) begin
                    awaited_q.push_back(status_word('0, ERR_OVERFLOW, 1'b1));
                end else if (pos < 1 || pos > occupancy) begin
                    awaited_q.push_back(status_word('0, ERR_POSITION, 1'b1));
                end else begin
                    for (i = occupancy; i >= pos; i--) begin
                        ring[slot_of(i)] = ring[slot_of(i - 1)];
                    end
                    ring[slot_of(pos - 1)] = ch;
                    occupancy++;
                    awaited_q.push_back(status_word('0, ERR_OK, 1'b1));
                end
            end
            CMD_DUMP: begin
                if (occupancy == 0) begin
                    awaited_q.push_back(status_word('0, ERR_OK, 1'b1));
                end else begin
                    for (i = 0; i < occupancy; i++) begin
                        awaited_q.push_back(status_word(ring[slot_of(i)], ERR_OK,
                                                        i + 1 == occupancy));
                    end
                end
            end
            CMD_CLEAR: begin
                head_slot = 0;
                occupancy = 0;
                awaited_q.push_back(status_word('0, ERR_OK, 1'b1));
            end
            default: begin
                awaited_q.push_back(status_word('0, ERR_OK, 1'b1));
            end
        endcase
    endfunction

    function automatic void check_field(string field, logic [CHAR_W-1:0] want,
                                        logic [CHAR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result_word want;
        if (!i_rst_n) begin
            awaited_q.delete();
            head_slot = 0;
            occupancy = 0;
        end else begin
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1) begin
                predict_command(i_cmd.cmd, i_cmd.in_char, i_cmd.position);
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (awaited_q.size() == 0) begin
                    $error("result word with none awaited: out_char %0d fill_count %0d",
                           i_res.out_char, i_res.fill_count);
                    o_fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    check_field("out_char", want.ch, i_res.out_char);
                    check_field("fill_count", CHAR_W'(want.fill), CHAR_W'(i_res.fill_count));
                    check_field("is_empty", CHAR_W'(want.empty), CHAR_W'(i_res.is_empty));
                    check_field("error_code", CHAR_W'(want.err), CHAR_W'(i_res.error_code));
                    check_field("last", CHAR_W'(want.last), CHAR_W'(i_res.last));
                end
            end
        end
        o_pending = awaited_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character queue testbench
// Drives command words into the queue with random gaps, takes result words
// with random stalls, and leaves prediction and comparison to the checker
// beside the block. A directed opening covers the empty, refused and edge
// cases; random episodes of mixed traffic, fill bursts and drains follow.
// ----------------------------------------------------------------------------
module tb_top;
    import cqkr_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 136;
    // Time left after the last result for stray words to show up.
    localparam int TAIL_CYCLES  = 64;
    // Length of the one long stall on the result side.
    localparam int LONG_HOLD    = 300;

    // The two command codes that the queue treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   words_sent;
    // When set, neither side inserts gaps or stalls.
    bit   quiet_phase;
    // Asks the result side for one long stall.
    bit   hold_request;

    cqkr_in_if  cmd_ch ();
    cqkr_out_if res_ch ();

    char_queue_with_key_remove_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    cqkr_result_check #(
        .DEPTH(DEPTH)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("char_queue_with_key_remove_top: mismatch");
        $finish;
    end

    // Characters are drawn mostly from a tiny alphabet, so that remove-key
    // finds repeated matches; the rest cover the whole byte range.
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 2) == 0) begin
            return CHAR_W'($urandom_range(0, 255));
        end
        return 8'h41 + CHAR_W'($urandom_range(0, 3));
    endfunction

    // Positions are mostly legal; now and then anything the field can hold,
    // zero and values above the depth included.
    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 4) == 0) begin
            return POS_W'($urandom_range(0, 31));
        end
        return POS_W'($urandom_range(1, DEPTH));
    endfunction

    // Offers one command word after a random gap and returns at the edge on
    // which it is accepted. Valid is left high, so that a following word with
    // no gap goes out back to back.
    task automatic send_word(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                             logic [POS_W-1:0] pos);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= op;
        cmd_ch.in_char  <= ch;
        cmd_ch.position <= pos;
        do @(posedge clk); while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
        words_sent++;
    endtask

    // Stops offering and waits until every awaited result word has come. The
    // extra edge first lets the checker record the word just accepted.
    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Result side: a random stall before each word, and one long hold when
    // asked, during which the command side keeps pushing so that the queue
    // backs up and refuses further words.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 10);
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
        end
    end

    initial begin
        int          directed_words;
        int          episode;
        int unsigned roll;
        int unsigned burst;

        quiet_phase      = 1'b0;
        hold_request     = 1'b0;
        words_sent       = 0;
        rst_n           <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.cmd      <= CMD_PUSH;
        cmd_ch.in_char  <= '0;
        cmd_ch.position <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. The empty queue comes first: pop underflows, dump
        // gives a single closing word, and an insert at position one is refused.
        send_word(CMD_POP,    8'h00, 5'd1);
        send_word(CMD_DUMP,   8'h00, 5'd1);
        send_word(CMD_INSERT, 8'h11, 5'd1);
        send_word(CMD_REMOVE, 8'h11, 5'd1);
        // Extreme characters, then inserts at the head and before the tail.
        send_word(CMD_PUSH,   8'h00, 5'd1);
        send_word(CMD_PUSH,   8'hFF, 5'd1);
        send_word(CMD_PUSH,   8'h80, 5'd1);
        send_word(CMD_INSERT, 8'h5A, 5'd1);
        send_word(CMD_INSERT, 8'h7F, 5'd4);
        // Positions of zero, one past the tail and the largest the field holds.
        send_word(CMD_INSERT, 8'h01, 5'd0);
        send_word(CMD_INSERT, 8'h01, 5'd6);
        send_word(CMD_INSERT, 8'h01, 5'd31);
        send_word(CMD_DUMP,   8'h00, 5'd1);
        // A key held twice, then a key that is absent.
        send_word(CMD_PUSH,   8'hFF, 5'd16);
        send_word(CMD_REMOVE, 8'hFF, 5'd1);
        send_word(CMD_REMOVE, 8'h33, 5'd1);
        send_word(CMD_POP,    8'h00, 5'd1);
        // Unused codes do nothing but answer once.
        send_word(CMD_SPARE_6, 8'hAA, 5'd21);
        send_word(CMD_SPARE_7, 8'h55, 5'd10);
        send_word(CMD_DUMP,   8'h00, 5'd1);
        send_word(CMD_CLEAR,  8'h00, 5'd1);
        send_word(CMD_DUMP,   8'h00, 5'd1);
        send_word(CMD_POP,    8'h00, 5'd1);
        directed_words = words_sent;

        // Pause the command side until the queue has answered everything.
        wait_for_drain();

        // Random episodes. The second is always a fill burst with the long
        // hold on the result side, so that the block is seen to back up.
        episode = 0;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            roll        = (episode == 1) ? 1 : $urandom_range(0, 3);
            case (roll)
                1: begin
                    // Enough pushes to fill the queue from any level, so the
                    // last ones overflow; an insert on the full queue must
                    // report overflow whatever its position.
                    if (episode == 1) begin
                        hold_request = 1'b1;
                    end
                    burst = DEPTH + $urandom_range(1, 2);
                    repeat (burst) send_word(CMD_PUSH, pick_char(), pick_position());
                    send_word(CMD_INSERT, pick_char(), pick_position());
                    send_word(CMD_DUMP, pick_char(), pick_position());
                    send_word(CMD_REMOVE, pick_char(), pick_position());
                    send_word(CMD_DUMP, pick_char(), pick_position());
                end
                2: begin
                    // Drain, often past empty, so that the head wraps the ring.
                    repeat ($urandom_range(3, DEPTH + 2)) begin
                        send_word(CMD_POP, pick_char(), pick_position());
                    end
                    send_word(CMD_DUMP, pick_char(), pick_position());
                end
                default: begin
                    // Mixed traffic, weighted towards growth so that inserts
                    // and removes work on well-filled queues.
                    repeat (20) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 35) begin
                            send_word(CMD_PUSH, pick_char(), pick_position());
                        end else if (roll < 55) begin
                            send_word(CMD_INSERT, pick_char(), pick_position());
                        end else if (roll < 72) begin
                            send_word(CMD_POP, pick_char(), pick_position());
                        end else if (roll < 82) begin
                            send_word(CMD_REMOVE, pick_char(), pick_position());
                        end else if (roll < 94) begin
                            send_word(CMD_DUMP, pick_char(), pick_position());
                        end else if (roll < 97) begin
                            send_word(CMD_CLEAR, pick_char(), pick_position());
                        end else begin
                            send_word(roll[0] ? CMD_SPARE_6 : CMD_SPARE_7,
                                      pick_char(), pick_position());
                        end
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                wait_for_drain();
            end
            episode++;
        end

        // Let every awaited word arrive, then watch a while for strays.
        quiet_phase = 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("char_queue_with_key_remove_top: match");
        end else begin
            $display("char_queue_with_key_remove_top: mismatch");
        end
        $finish;
    end

endmodule
